>>> rtl/dce_pkg.sv
// Package for the device count estimator: sizes, constants, transaction
// structs, controller state encoding and the estimate function.
// Depends on nothing; every other file of the block imports it.
package dce_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ID_W        = 8;
	localparam int CHAN_W      = 8;
	localparam int CRED_W      = 8;
	localparam int SEED_W      = 9;
	localparam int EST_W       = 8;
	localparam int IDX_EXT_W   = IDX_W + ID_W;
	localparam int SEED_CMP_W  = (CNT_W > SEED_W) ? CNT_W : SEED_W;

	localparam logic [CRED_W-1:0] SEED_FIRST      = 8'd3;
	localparam logic [CRED_W-1:0] SEED_LAST       = 8'd5;
	localparam logic [CRED_W-1:0] ANNOUNCE_CREDIT = 8'd5;
	localparam logic [CRED_W-1:0] CREDIT_CAP      = 8'd128;
	localparam logic [CRED_W-1:0] TICK_DEBIT      = 8'd1;
	localparam logic [EST_W-1:0]  EST_FLOOR       = 8'd8;
	localparam logic [EST_W-1:0]  EST_CEIL        = 8'd255;
	localparam logic [SEED_W-1:0] SEED_RESET      = 9'd32;

	localparam logic [1:0] REQ_ANNOUNCE = 2'd0;
	localparam logic [1:0] REQ_TICK     = 2'd1;
	localparam logic [1:0] REQ_RESEED   = 2'd2;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [ID_W-1:0]   device_id;
		logic [CHAN_W-1:0] chan_type;
	} req_item_t;

	typedef struct packed {
		logic [EST_W-1:0]  estimate;
		logic [CHAN_W-1:0] worst_chan;
		logic              chan_changed;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ANNOUNCE,
		ST_TICK,
		ST_SEED,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic accept;
		logic ann_commit;
		logic tick_step;
		logic seed_step;
		logic seed_clear;
		logic report_load;
	} cmd_t;

	typedef struct packed {
		logic tick_last;
		logic seed_last;
	} status_t;

	// Estimate from the exact live count: max(8, min(255, 1 + C + C*C/256)),
	// where C is the live count saturated at 255.
	function automatic logic [EST_W-1:0] estimate_of(input logic [CNT_W-1:0] count);
		logic [CNT_W+7:0] count_ext;
		logic [7:0]       c;
		logic [15:0]      sq;
		logic [9:0]       v;
		count_ext = {8'b0, count};
		c = (count_ext > (CNT_W + 8)'(255)) ? 8'd255 : count_ext[7:0];
		sq = c * c;
		v = 10'd1 + {2'b0, c} + {2'b0, sq[15:8]};
		if (v > {2'b0, EST_CEIL}) begin
			v = {2'b0, EST_CEIL};
		end
		if (v < {2'b0, EST_FLOOR}) begin
			v = {2'b0, EST_FLOOR};
		end
		return v[EST_W-1:0];
	endfunction

endpackage

>>> rtl/device_count_estimator_unit.sv
// Top level of the device count estimator: controller plus datapath.
// Depends on dce_pkg, dce_ctrl and dce_datapath.
//
// The block keeps one credit counter per device id and returns, for every
// request transaction on the req channel, one result transaction on the rsp
// channel with the estimated device count and the slowest channel type seen.
// Both channels use valid/ready; cfg is a write-only channel for the seed
// count and is always ready, so a write lands at the edge its valid is high.
//
// An announcement is accepted and its counter is read from the table memory;
// once the output register is free, the updated counter is written back and
// the result register loads, which raises rsp_valid. A tick walks the whole
// table through the single read port and single write port, one entry a
// cycle; a reseed writes one entry a cycle. An unused request code goes
// straight to reporting. One request is worked on at a time; req_ready is
// high only while idle.
//
// After reset the controller sweeps zeros through every table entry with
// req_ready low; cfg writes are still taken meanwhile. When the receiver
// stalls, the result waits in the output register; a new request is still
// accepted, and its result waits until the register frees.
module device_count_estimator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  dce_pkg::req_item_t         req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output dce_pkg::rsp_item_t         rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [dce_pkg::SEED_W-1:0] cfg_data
);
	import dce_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The seed register can be written at any time.
	assign cfg_ready = 1'b1;

	dce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dce_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.req_data (req),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.rsp_data (rsp)
	);

endmodule

>>> rtl/dce_ctrl.sv
// Controller state machine of the device count estimator.
// Depends on dce_pkg; drives the datapath through cmd_t and reads status_t.
module dce_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_type,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	input  dce_pkg::status_t status,
	output dce_pkg::cmd_t    cmd
);
	import dce_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	// The output register can take a new result when empty or being drained.
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.seed_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					case (req_type)
						REQ_ANNOUNCE: state_d = ST_ANNOUNCE;
						REQ_TICK:     state_d = ST_TICK;
						REQ_RESEED:   state_d = ST_SEED;
						default:      state_d = ST_REPORT;
					endcase
				end
			end
			ST_ANNOUNCE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				if (status.tick_last) begin
					state_d = ST_REPORT;
				end
			end
			ST_SEED: begin
				if (status.seed_last) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.seed_step  = 1'b1;
				cmd.seed_clear = 1'b1;
			end
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			ST_ANNOUNCE: begin
				cmd.ann_commit = slot_free;
			end
			ST_TICK: begin
				cmd.tick_step = 1'b1;
			end
			ST_SEED: begin
				cmd.seed_step = 1'b1;
			end
			ST_REPORT: begin
				cmd.report_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ann_commit || cmd.report_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/dce_datapath.sv
// Datapath of the device count estimator: credit table memory, table walker,
// live count, worst channel, seed register and the result register.
// Depends on dce_pkg; controlled by dce_ctrl through cmd_t.
module dce_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dce_pkg::cmd_t              cmd,
	output dce_pkg::status_t           status,
	input  dce_pkg::req_item_t         req_data,
	input  logic                       cfg_we,
	input  logic [dce_pkg::SEED_W-1:0] cfg_data,
	output dce_pkg::rsp_item_t         rsp_data
);
	import dce_pkg::*;

	logic [CRED_W-1:0] credit_mem [TABLE_DEPTH];
	logic [CRED_W-1:0] rd_data_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CRED_W-1:0] wr_data;

	logic [SEED_W-1:0] seed_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  walk_idx_q;
	logic [CNT_W-1:0]  live_acc_q;
	logic              walk_wr_s1;
	logic [IDX_W-1:0]  walk_addr_s1;
	logic [CRED_W-1:0] seed_pat_q;
	logic [CHAN_W-1:0] worst_q;

	logic [IDX_W-1:0]  ann_addr_q;
	logic              ann_hit_q;
	logic [CHAN_W-1:0] chan_q;
	rsp_item_t         rsp_q;

	logic [IDX_EXT_W-1:0]  id_ext;
	logic [IDX_W-1:0]      req_addr;
	logic                  req_hit;
	logic [IDX_W-1:0]      walk_addr;
	logic                  walk_in_table;
	logic [SEED_CMP_W-1:0] seed_ext;
	logic [SEED_CMP_W-1:0] seed_n;
	logic                  seed_hit;
	logic [CRED_W:0]       cred_sum;
	logic [CRED_W-1:0]     ann_credit;
	logic [CNT_W-1:0]      count_ann;
	logic                  chan_up;
	logic [CHAN_W-1:0]     worst_next;
	logic                  tick_live;
	logic [CRED_W-1:0]     tick_credit;
	logic [CNT_W-1:0]      tick_total;

	// Device ids beyond the table carry no credit.
	assign id_ext   = {IDX_W'(0), req_data.device_id};
	assign req_addr = id_ext[IDX_W-1:0];
	assign req_hit  = id_ext < IDX_EXT_W'(TABLE_DEPTH);

	assign walk_addr     = walk_idx_q[IDX_W-1:0];
	assign walk_in_table = walk_idx_q < CNT_W'(TABLE_DEPTH);

	assign seed_ext = SEED_CMP_W'(seed_q);
	assign seed_n   = (seed_ext > SEED_CMP_W'(TABLE_DEPTH)) ? SEED_CMP_W'(TABLE_DEPTH) : seed_ext;
	assign seed_hit = !cmd.seed_clear && (SEED_CMP_W'(walk_idx_q) < seed_n);

	assign cred_sum   = {1'b0, rd_data_q} + {1'b0, ANNOUNCE_CREDIT};
	assign ann_credit = (cred_sum > {1'b0, CREDIT_CAP}) ? CREDIT_CAP : cred_sum[CRED_W-1:0];
	assign count_ann  = count_q + CNT_W'(ann_hit_q && (rd_data_q == '0));
	assign chan_up    = chan_q > worst_q;
	assign worst_next = chan_up ? chan_q : worst_q;

	assign tick_live   = rd_data_q > TICK_DEBIT;
	assign tick_credit = tick_live ? (rd_data_q - TICK_DEBIT) : '0;
	assign tick_total  = live_acc_q + CNT_W'(walk_wr_s1 && tick_live);

	assign status.tick_last = walk_idx_q == CNT_W'(TABLE_DEPTH);
	assign status.seed_last = walk_idx_q == CNT_W'(TABLE_DEPTH - 1);

	assign rd_en   = (cmd.accept && (req_data.req_type == REQ_ANNOUNCE)) ||
	                 (cmd.tick_step && walk_in_table);
	assign rd_addr = cmd.tick_step ? walk_addr : req_addr;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = walk_addr;
		wr_data = '0;
		if (cmd.ann_commit) begin
			wr_en   = ann_hit_q;
			wr_addr = ann_addr_q;
			wr_data = ann_credit;
		end else if (cmd.tick_step) begin
			wr_en   = walk_wr_s1;
			wr_addr = walk_addr_s1;
			wr_data = tick_credit;
		end else if (cmd.seed_step) begin
			wr_en   = 1'b1;
			wr_addr = walk_addr;
			wr_data = seed_hit ? seed_pat_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			credit_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= credit_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ann_addr_q <= req_addr;
			ann_hit_q  <= req_hit;
			chan_q     <= req_data.chan_type;
		end
		if (cmd.ann_commit) begin
			rsp_q.estimate     <= estimate_of(count_ann);
			rsp_q.worst_chan   <= worst_next;
			rsp_q.chan_changed <= chan_up;
		end else if (cmd.report_load) begin
			rsp_q.estimate     <= estimate_of(count_q);
			rsp_q.worst_chan   <= worst_q;
			rsp_q.chan_changed <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= SEED_RESET;
			count_q      <= '0;
			worst_q      <= '0;
			walk_idx_q   <= '0;
			live_acc_q   <= '0;
			walk_wr_s1   <= 1'b0;
			walk_addr_s1 <= '0;
			seed_pat_q   <= SEED_FIRST;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_data;
			end
			if (cmd.ann_commit) begin
				count_q <= count_ann;
				worst_q <= worst_next;
			end
			// The tick walk reads one entry a cycle and writes it back in the next cycle.
			if (cmd.tick_step) begin
				if (status.tick_last) begin
					walk_idx_q <= '0;
					walk_wr_s1 <= 1'b0;
					live_acc_q <= '0;
					count_q    <= tick_total;
				end else begin
					walk_idx_q   <= walk_idx_q + CNT_W'(1);
					walk_wr_s1   <= 1'b1;
					walk_addr_s1 <= walk_addr;
					live_acc_q   <= tick_total;
				end
			end
			if (cmd.seed_step) begin
				if (status.seed_last) begin
					walk_idx_q <= '0;
					seed_pat_q <= SEED_FIRST;
					count_q    <= cmd.seed_clear ? '0 : CNT_W'(seed_n);
				end else begin
					walk_idx_q <= walk_idx_q + CNT_W'(1);
					seed_pat_q <= (seed_pat_q == SEED_LAST) ? SEED_FIRST :
					              seed_pat_q + CRED_W'(1);
				end
			end
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> rtl/dce_checker.sv
// Port-level checker for the device count estimator and its bind statement.
// Depends on dce_pkg and attaches to device_count_estimator_unit.
module dce_port_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input dce_pkg::rsp_item_t rsp
);
	import dce_pkg::*;

	// A stalled result transaction stays valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp_valid dropped while stalled");

	// A stalled result transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("rsp payload changed while stalled");

	// One request at a time: no accept in the cycle after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// The estimate never falls below its floor.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.estimate >= EST_FLOOR)
		else $error("estimate below floor");

	// A raised worst channel type cannot be zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.chan_changed |-> rsp.worst_chan != '0)
		else $error("channel change reported with zero worst channel");

endmodule

bind device_count_estimator_unit dce_port_checker u_dce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

>>> dv/dce_checker.sv
// Checker for the device count estimator: watches the req, rsp and cfg channels,
// keeps its own copy of the credit table and seed count, and compares results.
// Depends on dce_pkg for the transaction structs, request codes and sizes.
module dce_checker
	import dce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  req_item_t         req,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  rsp_item_t         rsp,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [SEED_W-1:0] cfg_data,
	output int                errors,
	output int                pending,
	output int                results,
	output int                raises,
	output int                ceilings
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANNOUNCE_GAIN = 5;
	localparam int CREDIT_LIMIT  = 128;
	localparam int PATTERN_LOW   = 3;
	localparam int PATTERN_HIGH  = 5;
	localparam int ESTIMATE_MIN  = 8;
	localparam int ESTIMATE_MAX  = 255;
	localparam int LIVE_LIMIT    = 255;

	logic [CRED_W-1:0] credits [TABLE_DEPTH];
	logic [CHAN_W-1:0] slowest_chan;
	logic [SEED_W-1:0] seed_count;
	rsp_item_t         awaited_rsp [$];

	function automatic logic [EST_W-1:0] estimate_for(int unsigned live);
		int unsigned v;
		v = 1 + live + (live * live) / 256;
		if (v > ESTIMATE_MAX) begin
			v = ESTIMATE_MAX;
		end
		if (v < ESTIMATE_MIN) begin
			v = ESTIMATE_MIN;
		end
		return v[EST_W-1:0];
	endfunction

	// Applies one request to the shadow table and returns the result it causes.
	function automatic rsp_item_t serve_request(req_item_t r);
		rsp_item_t   outcome;
		int unsigned live;
		int unsigned sum;
		int          span;
		int          pattern;
		outcome.chan_changed = 1'b0;
		case (r.req_type)
			REQ_ANNOUNCE: begin
				if (int'(r.device_id) < TABLE_DEPTH) begin
					sum = credits[r.device_id] + ANNOUNCE_GAIN;
					credits[r.device_id] = CRED_W'((sum > CREDIT_LIMIT) ? CREDIT_LIMIT : sum);
				end
				if (r.chan_type > slowest_chan) begin
					slowest_chan = r.chan_type;
					outcome.chan_changed = 1'b1;
				end
			end
			REQ_TICK: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					credits[i] = (credits[i] > 1) ? CRED_W'(credits[i] - 1) : '0;
				end
			end
			REQ_RESEED: begin
				span = (seed_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(seed_count);
				pattern = PATTERN_LOW;
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					credits[i] = '0;
				end
				for (int i = 0; i < span; i++) begin
					credits[i] = CRED_W'(pattern);
					pattern = (pattern == PATTERN_HIGH) ? PATTERN_LOW : pattern + 1;
				end
			end
			default: begin
			end
		endcase
		live = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (credits[i] != 0 && live < LIVE_LIMIT) begin
				live++;
			end
		end
		outcome.estimate = estimate_for(live);
		outcome.worst_chan = slowest_chan;
		return outcome;
	endfunction

	function automatic int field_differs(string name, int want, int got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_item_t want;
		int        bad;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				credits[i] = '0;
			end
			slowest_chan = '0;
			seed_count = 9'd32;
			awaited_rsp.delete();
			errors <= 0;
			pending <= 0;
			results <= 0;
			raises <= 0;
			ceilings <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected result, expected none, got estimate %0d worst_chan %0d",
						$time, rsp.estimate, rsp.worst_chan);
					errors <= errors + 1;
				end else begin
					want = awaited_rsp.pop_front();
					bad = field_differs("estimate", int'(want.estimate), int'(rsp.estimate))
						+ field_differs("worst_chan", int'(want.worst_chan), int'(rsp.worst_chan))
						+ field_differs("chan_changed", int'(want.chan_changed),
							int'(rsp.chan_changed));
					errors <= errors + bad;
				end
				results <= results + 1;
				raises <= raises + (rsp.chan_changed === 1'b1);
				ceilings <= ceilings + (rsp.estimate === EST_W'(ESTIMATE_MAX));
			end
			if (cfg_valid && cfg_ready) begin
				seed_count = cfg_data;
			end
			if (req_valid && req_ready) begin
				awaited_rsp.push_back(serve_request(req));
			end
			pending <= awaited_rsp.size();
		end
	end

endmodule

>>> dv/tb.sv
// Testbench top for the device count estimator: clock, reset, stimulus and verdict.
// Depends on dce_pkg, device_count_estimator_unit and dce_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dce_pkg::*;

	// The request code that the block must treat as a no-op.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Ticks and reseeds walk the whole table; the limit below is many times the
	// slowest legal run, including the clearing sweep after reset.
	localparam int LIMIT_CYCLES = 1000000;
	localparam int LONG_HOLD    = 400;
	localparam int PHASE_ITEMS  = 125;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	req_item_t         req;
	logic              rsp_valid;
	logic              rsp_ready;
	rsp_item_t         rsp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SEED_W-1:0] cfg_data;

	int chk_errors;
	int chk_pending;
	int chk_results;
	int chk_raises;
	int chk_ceilings;

	// Stimulus-side knobs. stall_pct and hold_arm are read by the receiver
	// process, so they are only ever changed with nonblocking assignments.
	int idle_pct;
	int stall_pct;
	int hold_arm;
	int hold_seen;
	int hold_left;
	int chan_ramp;
	int sent;
	int cycle_count;

	device_count_estimator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	dce_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (chk_errors),
		.pending   (chk_pending),
		.results   (chk_results),
		.raises    (chk_raises),
		.ceilings  (chk_ceilings)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The watchdog ends a run that hangs on a handshake that never comes.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: run exceeded %0d cycles", $time, LIMIT_CYCLES);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver. It stalls at random with probability stall_pct, and whenever
	// the stimulus bumps hold_arm it holds rsp_ready low while hold_left counts
	// down from LONG_HOLD, so that the result register fills and req_ready drops.
	always @(posedge clk) begin
		if (hold_arm != hold_seen) begin
			hold_seen <= hold_arm;
			hold_left <= LONG_HOLD;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic req_item_t request_of(logic [1:0] kind, logic [ID_W-1:0] id,
		logic [CHAN_W-1:0] chan);
		req_item_t item;
		item.req_type = kind;
		item.device_id = id;
		item.chan_type = chan;
		return item;
	endfunction

	// The slowest channel never goes down, so channel types follow a slowly
	// rising ramp; random values up to it keep most announcements from raising
	// it, and picking the ramp itself raises it whenever the ramp has moved.
	// The ramp stops short of the top value, which is kept for the very end.
	function automatic logic [CHAN_W-1:0] pick_chan();
		if ($urandom_range(0, 99) < 60 && chan_ramp < 254) begin
			chan_ramp++;
		end
		if ($urandom_range(0, 3) == 0) begin
			return CHAN_W'(chan_ramp);
		end
		return CHAN_W'($urandom_range(0, chan_ramp));
	endfunction

	// Offers one request transaction and returns at the edge that accepts it.
	// valid stays high on return; it is only lowered when a gap is inserted or
	// the sender goes quiet, so it is never lowered and raised in one step.
	task automatic offer_request(req_item_t item);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do begin
			@(posedge clk);
		end while (!req_ready);
		sent++;
	endtask

	// The sender goes quiet until every predicted result has been received.
	// chk_pending is updated with nonblocking assignments, so the value seen
	// at an edge describes the state after the previous edge.
	task automatic drain_results();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (chk_pending != 0);
	endtask

	// Every request causes a result, so once drained the block is idle and the
	// seed count can be written safely.
	task automatic write_seed_count(logic [SEED_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random traffic built from short well-formed runs: bursts on one device
	// id that push its counter toward the cap, runs of aging ticks, reseeds,
	// scattered announcements and the occasional unused request code.
	task automatic run_traffic(int count);
		int             done;
		int             pick;
		int             len;
		logic [ID_W-1:0] id;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				id = ID_W'($urandom_range(0, 255));
				len = $urandom_range(20, 32);
				for (int i = 0; i < len; i++) begin
					offer_request(request_of(REQ_ANNOUNCE, id, pick_chan()));
				end
				done += len;
			end else if (pick < 20) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					offer_request(request_of(REQ_TICK, ID_W'($urandom_range(0, 255)),
						CHAN_W'($urandom_range(0, 255))));
				end
				done += len;
			end else if (pick < 25) begin
				offer_request(request_of(REQ_RESEED, ID_W'($urandom_range(0, 255)),
					CHAN_W'($urandom_range(0, 255))));
				done++;
			end else if (pick < 29) begin
				offer_request(request_of(REQ_UNUSED, ID_W'($urandom_range(0, 255)),
					CHAN_W'($urandom_range(0, 255))));
				done++;
			end else begin
				for (int i = 0; i < 8; i++) begin
					id = ($urandom_range(0, 1) == 1) ? ID_W'($urandom_range(0, 7))
						: ID_W'($urandom_range(0, 255));
					offer_request(request_of(REQ_ANNOUNCE, id, pick_chan()));
				end
				done += 8;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		idle_pct = 0;
		stall_pct <= 0;
		chan_ramp = 3;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The seed count is left at its reset value first.
		// The block clears its table after reset, so the first offer simply
		// waits for req_ready.
		offer_request(request_of(REQ_ANNOUNCE, 8'h00, 8'h00));
		offer_request(request_of(REQ_ANNOUNCE, 8'hFF, 8'h01));
		offer_request(request_of(REQ_ANNOUNCE, 8'hAA, 8'h02));
		// An equal channel type must not count as a raise.
		offer_request(request_of(REQ_ANNOUNCE, 8'h55, 8'h02));
		// The unused code changes nothing, even with the largest channel type.
		offer_request(request_of(REQ_UNUSED, 8'hFF, 8'hFF));
		offer_request(request_of(REQ_TICK, 8'h00, 8'h00));
		offer_request(request_of(REQ_RESEED, 8'h00, 8'h00));
		// Five ticks walk the seed pattern 3,4,5 down to an empty table.
		for (int i = 0; i < 5; i++) begin
			offer_request(request_of(REQ_TICK, 8'hFF, 8'hFF));
		end

		// A full-table seed saturates the live count and the estimate.
		drain_results();
		write_seed_count(9'd256);
		offer_request(request_of(REQ_RESEED, 8'h00, 8'h00));
		offer_request(request_of(REQ_ANNOUNCE, 8'hFF, 8'h03));
		offer_request(request_of(REQ_TICK, 8'h00, 8'h00));

		// A seed count above the table depth seeds the whole table.
		drain_results();
		write_seed_count(9'd511);
		offer_request(request_of(REQ_RESEED, 8'h00, 8'h00));

		// A zero seed count leaves the table empty and the estimate at its floor.
		drain_results();
		write_seed_count(9'd0);
		offer_request(request_of(REQ_RESEED, 8'h00, 8'h00));
		offer_request(request_of(REQ_ANNOUNCE, 8'h00, 8'h00));

		drain_results();
		write_seed_count(9'd1);
		offer_request(request_of(REQ_RESEED, 8'h00, 8'h00));
		offer_request(request_of(REQ_TICK, 8'h00, 8'h00));

		// Random part in four phases: no idling, sender idle, receiver stalling,
		// and both idling lightly. Each phase starts with a new seed count.
		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			case (phase)
				0: begin
					write_seed_count(9'd256);
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					write_seed_count(SEED_W'($urandom_range(2, 255)));
					idle_pct = 87;
					stall_pct <= 0;
				end
				2: begin
					write_seed_count(9'd3);
					idle_pct = 0;
					stall_pct <= 87;
				end
				default: begin
					write_seed_count(SEED_W'($urandom_range(0, 511)));
					idle_pct = 10;
					stall_pct <= 10;
				end
			endcase
			run_traffic(PHASE_ITEMS);

			// Back pressure: the receiver holds off for a long stretch while the
			// sender keeps offering announcements, so the block fills up and
			// drops req_ready; then the sender waits for everything to drain.
			if (phase == 1) begin
				drain_results();
				idle_pct = 0;
				stall_pct <= 0;
				hold_arm <= hold_arm + 1;
				for (int i = 0; i < 8; i++) begin
					offer_request(request_of(REQ_ANNOUNCE, ID_W'($urandom_range(0, 255)),
						pick_chan()));
				end
				drain_results();
			end
		end

		// The largest channel type raises the slowest channel once, then not again.
		offer_request(request_of(REQ_ANNOUNCE, ID_W'($urandom_range(0, 255)), 8'hFF));
		offer_request(request_of(REQ_ANNOUNCE, ID_W'($urandom_range(0, 255)), 8'hFF));

		drain_results();
		// Give a stray late result time to show up before the verdict.
		repeat (TABLE_DEPTH + 16) @(posedge clk);
		if (chk_pending != 0) begin
			$display("%0t: %0d results still outstanding at the end", $time, chk_pending);
		end
		$display("covered %0d requests and %0d results over four traffic phases,",
			sent, chk_results);
		$display("with %0d channel raises and %0d results at the estimate ceiling",
			chk_raises, chk_ceilings);
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
